/* hw/rtl/slip_rrb_pkg.sv */
// slip_rrb_pkg: types and constants for the slip receive ring buffer
// request and result structs, slip byte codes, result kinds, mode and fsm enums
// no dependencies
package slip_rrb_pkg;

	localparam int unsigned BUF_DEPTH_DEF = 64;
	localparam int unsigned RES_LIMIT = 64;
	localparam logic [6:0] MAX_LEN_RST = 7'd62;

	localparam logic [7:0] CH_END = 8'o300;
	localparam logic [7:0] CH_ESC = 8'o333;
	localparam logic [7:0] CH_ESC_END = 8'o334;
	localparam logic [7:0] CH_ESC_ESC = 8'o335;

	localparam logic CMD_BYTE = 1'b0;
	localparam logic CMD_POLL = 1'b1;

	localparam logic [1:0] KIND_STATUS = 2'd0;
	localparam logic [1:0] KIND_DATA = 2'd1;
	localparam logic [1:0] KIND_NONE = 2'd2;

	// register index, taken from paddr[2]
	localparam logic REG_MAX_LENGTH = 1'b0;

	typedef enum logic [1:0] {
		MODE_NORMAL = 2'd0,
		MODE_ESC = 2'd1,
		MODE_DISCARD = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'd0,
		ST_COUNT = 2'd1,
		ST_EMIT = 2'd2,
		ST_SCAN = 2'd3
	} fsm_t;

	typedef struct packed {
		logic command;
		logic [7:0] byte_value;
	} slip_req_t;

	typedef struct packed {
		logic [1:0] result_kind;
		logic [7:0] out_byte;
		logic last;
		logic frame_ready;
	} slip_rsp_t;

endpackage

/* hw/rtl/slip_rrb_ram.sv */
// slip_rrb_ram: generic single-port-write, single-port-read ram
// registered read data; no dependencies
module slip_rrb_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 64
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic re,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* hw/rtl/slip_receive_ring_buffer.sv */
// slip_receive_ring_buffer: slip receiver storing escaped line bytes in a ring
// depends on slip_rrb_pkg and slip_rrb_ram
//
// channel   | direction | handshake                    | payload
// ----------+-----------+------------------------------+---------------------
// request   | in        | start, busy (taken when !busy)| req (slip_req_t)
// result    | out       | rsp_valid strobe, one cycle  | rsp (slip_rsp_t)
// config    | in/out    | apb, pready tied high        | max_length at 0x0
//
// a line byte, or a poll with nothing ready, is handled without leaving idle and busy stays low
// any other poll holds busy while the stored bytes are read once to count and once to emit (only
// to count when dropped), then the entries up to the next END or the write pointer are scanned;
// one read port, one entry per cycle
// reset clears pointers and mode; the ring contents are not cleared
// results cannot be stalled: each is valid for exactly one cycle
module slip_receive_ring_buffer #(
	parameter int unsigned BUF_DEPTH = slip_rrb_pkg::BUF_DEPTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [2:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	input logic start,
	output logic busy,
	input slip_rrb_pkg::slip_req_t req,
	output logic rsp_valid,
	output slip_rrb_pkg::slip_rsp_t rsp
);
	import slip_rrb_pkg::*;

	localparam int unsigned PTR_W = $clog2(BUF_DEPTH);
	typedef logic [PTR_W-1:0] ptr_t;
	localparam ptr_t LAST_POS = PTR_W'(BUF_DEPTH - 1);

	function automatic ptr_t next_pos(input ptr_t p);
		return (p == LAST_POS) ? '0 : p + 1'b1;
	endfunction

	fsm_t fsm_q, fsm_d;
	mode_t mode_q;
	ptr_t rs_q, pe_q, wi_q;
	ptr_t rd_ptr_q, addr_s1;
	logic v_s1;
	logic esc_q, over_q;
	logic [6:0] n_q, k_q;
	logic [6:0] max_len_q;
	logic rsp_valid_q, rsp_valid_d;
	slip_rsp_t rsp_q, rsp_d;

	logic accept, cfg_wr;
	logic [6:0] limit;
	logic [7:0] rdata;
	logic dec_have, dec_esc_n;
	logic [7:0] dec_val;
	ptr_t stop_ptr;
	logic walking, issue, found, walk_done, drop;

	mode_t b_mode;
	ptr_t b_wi, b_pe, b_nxt;
	logic b_we, b_ready, b_go;

	assign busy = (fsm_q != ST_IDLE);
	assign accept = start & ~busy;
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & (paddr[2] == REG_MAX_LENGTH);
	assign prdata = (paddr[2] == REG_MAX_LENGTH) ? {25'd0, max_len_q} : 32'd0;
	assign limit = (max_len_q > 7'(RES_LIMIT)) ? 7'(RES_LIMIT) : max_len_q;

	// unescape one stored byte
	always_comb begin
		dec_have = 1'b0;
		dec_val = '0;
		dec_esc_n = 1'b0;
		if (esc_q) begin
			if (rdata == CH_ESC_ESC) begin
				dec_val = CH_ESC;
				dec_have = 1'b1;
			end else if (rdata == CH_ESC_END) begin
				dec_val = CH_END;
				dec_have = 1'b1;
			end
		end else if (rdata == CH_ESC) begin
			dec_esc_n = 1'b1;
		end else begin
			dec_val = rdata;
			dec_have = 1'b1;
		end
	end

	// ring walk: one read issued per cycle, its data processed in the next cycle
	assign walking = (fsm_q == ST_COUNT) || (fsm_q == ST_EMIT) || (fsm_q == ST_SCAN);
	assign stop_ptr = (fsm_q == ST_SCAN) ? wi_q : pe_q;
	assign found = (fsm_q == ST_SCAN) && v_s1 && (rdata == CH_END);
	assign issue = walking && (rd_ptr_q != stop_ptr) && !found;
	assign walk_done = !issue && !v_s1;
	assign drop = over_q || (n_q == 7'd0);

	// line byte: pointer rules
	always_comb begin
		b_mode = mode_q;
		b_wi = wi_q;
		b_pe = pe_q;
		b_we = 1'b0;
		b_ready = 1'b0;
		b_go = 1'b1;
		b_nxt = next_pos(wi_q);
		case (mode_q)
			MODE_DISCARD: begin
				if (req.byte_value == CH_END) begin
					b_mode = MODE_NORMAL;
				end
				b_go = 1'b0;
			end
			MODE_ESC: begin
				if (req.byte_value != CH_ESC_END && req.byte_value != CH_ESC_ESC) begin
					b_mode = MODE_DISCARD;
					b_wi = pe_q;
					b_go = 1'b0;
				end else begin
					b_mode = MODE_NORMAL;
				end
			end
			default: ;
		endcase
		if (b_go) begin
			if (req.byte_value == CH_ESC) begin
				b_mode = MODE_ESC;
			end
			if (b_nxt == rs_q) begin
				// ring full: fall back to the last packet end
				b_mode = MODE_DISCARD;
				b_wi = pe_q;
			end else begin
				b_we = 1'b1;
				b_wi = b_nxt;
				if (req.byte_value == CH_END) begin
					if (wi_q != pe_q) begin
						if (rs_q == pe_q) begin
							b_pe = wi_q;
						end
						b_ready = 1'b1;
					end else begin
						b_wi = wi_q;
					end
				end
			end
		end
	end

	// next state
	always_comb begin
		fsm_d = fsm_q;
		case (fsm_q)
			ST_IDLE: begin
				if (accept && req.command == CMD_POLL && rs_q != pe_q) begin
					fsm_d = ST_COUNT;
				end
			end
			ST_COUNT: begin
				if (walk_done) begin
					fsm_d = drop ? ST_SCAN : ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (walk_done) begin
					fsm_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (found || walk_done) begin
					fsm_d = ST_IDLE;
				end
			end
			default: fsm_d = ST_IDLE;
		endcase
	end

	// results
	always_comb begin
		rsp_valid_d = 1'b0;
		rsp_d = '0;
		case (fsm_q)
			ST_IDLE: begin
				if (accept) begin
					if (req.command == CMD_BYTE) begin
						rsp_valid_d = 1'b1;
						rsp_d.result_kind = KIND_STATUS;
						rsp_d.last = 1'b1;
						rsp_d.frame_ready = b_ready;
					end else if (rs_q == pe_q) begin
						rsp_valid_d = 1'b1;
						rsp_d.result_kind = KIND_NONE;
						rsp_d.last = 1'b1;
					end
				end
			end
			ST_COUNT: begin
				if (walk_done && drop) begin
					rsp_valid_d = 1'b1;
					rsp_d.result_kind = KIND_NONE;
					rsp_d.last = 1'b1;
				end
			end
			ST_EMIT: begin
				if (v_s1 && dec_have) begin
					rsp_valid_d = 1'b1;
					rsp_d.result_kind = KIND_DATA;
					rsp_d.out_byte = dec_val;
					rsp_d.last = ((k_q + 7'd1) == n_q);
				end
			end
			default: ;
		endcase
	end

	slip_rrb_ram #(
		.WIDTH(8),
		.DEPTH(BUF_DEPTH)
	) u_ring (
		.clk(clk),
		.we(accept && req.command == CMD_BYTE && b_we),
		.waddr(wi_q),
		.wdata(req.byte_value),
		.re(issue),
		.raddr(rd_ptr_q),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fsm_q <= ST_IDLE;
			mode_q <= MODE_NORMAL;
			rs_q <= '0;
			pe_q <= '0;
			wi_q <= '0;
			v_s1 <= 1'b0;
			rsp_valid_q <= 1'b0;
			max_len_q <= MAX_LEN_RST;
		end else begin
			fsm_q <= fsm_d;
			v_s1 <= issue;
			rsp_valid_q <= rsp_valid_d;
			if (cfg_wr) begin
				max_len_q <= pwdata[6:0];
			end
			if (fsm_q == ST_IDLE && accept && req.command == CMD_BYTE) begin
				mode_q <= b_mode;
				wi_q <= b_wi;
				pe_q <= b_pe;
			end
			// free the packet and its END
			if ((fsm_q == ST_COUNT || fsm_q == ST_EMIT) && fsm_d == ST_SCAN) begin
				pe_q <= next_pos(pe_q);
			end
			if (fsm_q == ST_SCAN) begin
				if (found) begin
					rs_q <= pe_q;
					pe_q <= addr_s1;
				end else if (walk_done) begin
					rs_q <= pe_q;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= rd_ptr_q;
		rsp_q <= rsp_d;
		case (fsm_q)
			ST_IDLE: begin
				if (accept && req.command == CMD_POLL) begin
					rd_ptr_q <= rs_q;
					esc_q <= 1'b0;
					n_q <= '0;
					over_q <= 1'b0;
				end
			end
			ST_COUNT: begin
				if (issue) begin
					rd_ptr_q <= next_pos(rd_ptr_q);
				end
				if (v_s1) begin
					esc_q <= dec_esc_n;
					if (dec_have) begin
						if (n_q >= limit) begin
							over_q <= 1'b1;
						end else begin
							n_q <= n_q + 7'd1;
						end
					end
				end
				if (walk_done) begin
					rd_ptr_q <= drop ? next_pos(pe_q) : rs_q;
					esc_q <= 1'b0;
					k_q <= '0;
				end
			end
			ST_EMIT: begin
				if (issue) begin
					rd_ptr_q <= next_pos(rd_ptr_q);
				end
				if (v_s1) begin
					esc_q <= dec_esc_n;
					if (dec_have) begin
						k_q <= k_q + 7'd1;
					end
				end
				if (walk_done) begin
					rd_ptr_q <= next_pos(pe_q);
				end
			end
			ST_SCAN: begin
				if (issue) begin
					rd_ptr_q <= next_pos(rd_ptr_q);
				end
			end
			default: ;
		endcase
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

endmodule
